// ----- design/d2q9_pkg.sv -----
// Shared types, widths and saturation helper for the D2Q9 BGK collision pipeline.
package d2q9_pkg;

   localparam int POP_W         = 32;
   localparam int SUM_W         = 36;
   localparam int RATE_W        = 26;
   localparam int OMEGA_FRAC    = 24;
   localparam int FRAC_BITS_DEF = 24;
   localparam int NDIR          = 9;

   localparam logic [RATE_W-1:0] RATE_RESET = 26'd16777216;

   localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
   localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

   // one input word: the nine streamed populations
   typedef struct packed {
      logic signed [POP_W-1:0] pop_rest;
      logic signed [POP_W-1:0] pop_east;
      logic signed [POP_W-1:0] pop_north;
      logic signed [POP_W-1:0] pop_west;
      logic signed [POP_W-1:0] pop_south;
      logic signed [POP_W-1:0] pop_northeast;
      logic signed [POP_W-1:0] pop_northwest;
      logic signed [POP_W-1:0] pop_southwest;
      logic signed [POP_W-1:0] pop_southeast;
   } req_type;

   // one result word: the nine relaxed populations and the fault flag
   typedef struct packed {
      logic signed [POP_W-1:0] new_rest;
      logic signed [POP_W-1:0] new_east;
      logic signed [POP_W-1:0] new_north;
      logic signed [POP_W-1:0] new_west;
      logic signed [POP_W-1:0] new_south;
      logic signed [POP_W-1:0] new_northeast;
      logic signed [POP_W-1:0] new_northwest;
      logic signed [POP_W-1:0] new_southwest;
      logic signed [POP_W-1:0] new_southeast;
      logic                    density_fault;
   } rsp_type;

   // populations as a vector; direction q sits at index NDIR-1-q
   typedef logic [NDIR-1:0][POP_W-1:0] pop_vec_type;

   // data carried alongside the velocity divider
   typedef struct packed {
      pop_vec_type             pops;
      logic signed [POP_W-1:0] t_rest;
      logic signed [POP_W-1:0] t_axis;
      logic signed [POP_W-1:0] t_diag;
   } side_type;

   // clamp a wide signed value to 32 bits
   function automatic logic signed [POP_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [POP_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[POP_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[POP_W-1:0];
      end else begin
         r = v[POP_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- design/d2q9_moments.sv -----
// Moment sums (density, momentum) and weighted density terms, four stages.
module d2q9_moments #(
   parameter int FRAC_BITS = d2q9_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  d2q9_pkg::req_type                 in_data,
   output logic                              out_valid,
   output logic signed [d2q9_pkg::SUM_W-1:0] out_rho,
   output logic signed [d2q9_pkg::SUM_W-1:0] out_jx,
   output logic signed [d2q9_pkg::SUM_W-1:0] out_jy,
   output d2q9_pkg::side_type                out_side
);

   localparam int  SW    = d2q9_pkg::SUM_W;
   localparam int  WW    = FRAC_BITS + 2;
   localparam int  PLW   = WW + 19;
   localparam int  PHW   = WW + 18;
   localparam longint ONE_L  = longint'(1) << FRAC_BITS;
   localparam longint W_REST = (8 * ONE_L + 9) / 18;
   localparam longint W_AXIS = (2 * ONE_L + 9) / 18;
   localparam longint W_DIAG = (2 * ONE_L + 36) / 72;
   localparam logic signed [WW-1:0] WGT [3] = '{
      W_REST[WW-1:0], W_AXIS[WW-1:0], W_DIAG[WW-1:0]};

   d2q9_pkg::pop_vec_type   fv;
   logic signed [31:0]      f [9];

   // stage 1: partial sums
   logic                    s1_valid_ff;
   d2q9_pkg::pop_vec_type   s1_pops_ff;
   logic signed [34:0]      s1_ra_ff, s1_ra_in;
   logic signed [33:0]      s1_rd_ff, s1_rd_in;
   logic signed [32:0]      s1_sx_ff, s1_sx_in, s1_sy_ff, s1_sy_in;
   logic signed [32:0]      s1_d1_ff, s1_d1_in, s1_d2_ff, s1_d2_in;

   // stage 2: density and momentum
   logic                    s2_valid_ff;
   d2q9_pkg::pop_vec_type   s2_pops_ff;
   logic signed [SW-1:0]    s2_rho_ff, s2_rho_in, s2_jx_ff, s2_jx_in, s2_jy_ff, s2_jy_in;

   // stage 3: split products rho * weight
   logic                    s3_valid_ff;
   d2q9_pkg::pop_vec_type   s3_pops_ff;
   logic signed [SW-1:0]    s3_rho_ff, s3_jx_ff, s3_jy_ff;
   logic signed [PLW-1:0]   s3_lo_ff [3];
   logic signed [PLW-1:0]   s3_lo_in [3];
   logic signed [PHW-1:0]   s3_hi_ff [3];
   logic signed [PHW-1:0]   s3_hi_in [3];

   // stage 4: weighted densities
   logic                    s4_valid_ff;
   d2q9_pkg::side_type      s4_side_ff, s4_side_in;
   logic signed [SW-1:0]    s4_rho_ff, s4_jx_ff, s4_jy_ff;
   logic signed [31:0]      t_in [3];

   assign fv = d2q9_pkg::pop_vec_type'(in_data);

   always_comb begin
      for (int q = 0; q < 9; q++) begin
         f[q] = $signed(fv[8-q]);
      end
   end

   always_comb begin
      s1_ra_in = 35'(f[0]) + 35'(f[1]) + 35'(f[2]) + 35'(f[3]) + 35'(f[4]);
      s1_rd_in = 34'(f[5]) + 34'(f[6]) + 34'(f[7]) + 34'(f[8]);
      s1_sx_in = 33'(f[1]) - 33'(f[3]);
      s1_sy_in = 33'(f[2]) - 33'(f[4]);
      s1_d1_in = 33'(f[5]) - 33'(f[7]);
      s1_d2_in = 33'(f[6]) - 33'(f[8]);
   end

   always_comb begin
      s2_rho_in = SW'(s1_ra_ff) + SW'(s1_rd_ff);
      s2_jx_in  = SW'(s1_sx_ff) + SW'(s1_d1_ff) - SW'(s1_d2_ff);
      s2_jy_in  = SW'(s1_sy_ff) + SW'(s1_d1_ff) + SW'(s1_d2_ff);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s3_lo_in[i] = PLW'($signed({1'b0, s2_rho_ff[17:0]})) * PLW'(WGT[i]);
         s3_hi_in[i] = PHW'($signed(s2_rho_ff[SW-1:18])) * PHW'(WGT[i]);
      end
   end

   // recombine the halves, drop fraction bits, saturate
   always_comb begin
      logic signed [63:0] full;
      for (int i = 0; i < 3; i++) begin
         full    = (64'(s3_hi_ff[i]) <<< 18) + 64'(s3_lo_ff[i]);
         t_in[i] = d2q9_pkg::sat32(full >>> FRAC_BITS);
      end
      s4_side_in.pops   = s3_pops_ff;
      s4_side_in.t_rest = t_in[0];
      s4_side_in.t_axis = t_in[1];
      s4_side_in.t_diag = t_in[2];
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      s1_pops_ff <= fv;
      s1_ra_ff   <= s1_ra_in;
      s1_rd_ff   <= s1_rd_in;
      s1_sx_ff   <= s1_sx_in;
      s1_sy_ff   <= s1_sy_in;
      s1_d1_ff   <= s1_d1_in;
      s1_d2_ff   <= s1_d2_in;
      s2_pops_ff <= s1_pops_ff;
      s2_rho_ff  <= s2_rho_in;
      s2_jx_ff   <= s2_jx_in;
      s2_jy_ff   <= s2_jy_in;
      s3_pops_ff <= s2_pops_ff;
      s3_rho_ff  <= s2_rho_ff;
      s3_jx_ff   <= s2_jx_ff;
      s3_jy_ff   <= s2_jy_ff;
      for (int i = 0; i < 3; i++) begin
         s3_lo_ff[i] <= s3_lo_in[i];
         s3_hi_ff[i] <= s3_hi_in[i];
      end
      s4_side_ff <= s4_side_in;
      s4_rho_ff  <= s3_rho_ff;
      s4_jx_ff   <= s3_jx_ff;
      s4_jy_ff   <= s3_jy_ff;
   end

   assign out_valid = s4_valid_ff;
   assign out_rho   = s4_rho_ff;
   assign out_jx    = s4_jx_ff;
   assign out_jy    = s4_jy_ff;
   assign out_side  = s4_side_ff;

endmodule

// ----- design/d2q9_divider.sv -----
// Pipelined restoring divider: velocity = momentum * 2^F / density, one bit per stage.
module d2q9_divider #(
   parameter int FRAC_BITS = d2q9_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic signed [d2q9_pkg::SUM_W-1:0] in_rho,
   input  logic signed [d2q9_pkg::SUM_W-1:0] in_jx,
   input  logic signed [d2q9_pkg::SUM_W-1:0] in_jy,
   input  d2q9_pkg::side_type                in_side,
   output logic                              out_valid,
   output logic signed [FRAC_BITS+1:0]       out_ux,
   output logic signed [FRAC_BITS+1:0]       out_uy,
   output logic                              out_fault,
   output d2q9_pkg::side_type                out_side
);

   localparam int SW = d2q9_pkg::SUM_W;
   localparam int QW = FRAC_BITS + 1;
   localparam int UW = FRAC_BITS + 2;
   localparam logic signed [UW-1:0] U_MAX = {1'b0, {(UW-1){1'b1}}};
   localparam logic signed [UW-1:0] U_MIN = {1'b1, {(UW-1){1'b0}}};

   // per-stage state, stage 0 holds the top quotient bit
   logic                 valid_ff [QW];
   logic [SW-1:0]        rho_ff   [QW];
   logic [SW-1:0]        remx_ff  [QW];
   logic [SW-1:0]        remy_ff  [QW];
   logic [QW-1:0]        quox_ff  [QW];
   logic [QW-1:0]        quoy_ff  [QW];
   logic                 negx_ff  [QW];
   logic                 negy_ff  [QW];
   logic                 satx_ff  [QW];
   logic                 saty_ff  [QW];
   logic                 fault_ff [QW];
   d2q9_pkg::side_type   side_ff  [QW];

   logic                 ovalid_ff, ofault_ff;
   logic signed [UW-1:0] ux_ff, ux_in, uy_ff, uy_in;
   d2q9_pkg::side_type   oside_ff;

   logic [SW-1:0]        ax, ay;
   logic                 bx, by;

   // stage 0: magnitudes, overflow check, first quotient bit
   always_comb begin
      ax = in_jx[SW-1] ? SW'(-in_jx) : in_jx;
      ay = in_jy[SW-1] ? SW'(-in_jy) : in_jy;
      bx = ax >= in_rho;
      by = ay >= in_rho;
   end

   always_ff @(posedge clock) begin
      rho_ff[0]   <= in_rho;
      remx_ff[0]  <= bx ? ax - in_rho : ax;
      remy_ff[0]  <= by ? ay - in_rho : ay;
      quox_ff[0]  <= QW'(bx) << FRAC_BITS;
      quoy_ff[0]  <= QW'(by) << FRAC_BITS;
      negx_ff[0]  <= in_jx[SW-1];
      negy_ff[0]  <= in_jy[SW-1];
      satx_ff[0]  <= {1'b0, ax} >= {in_rho, 1'b0};
      saty_ff[0]  <= {1'b0, ay} >= {in_rho, 1'b0};
      fault_ff[0] <= in_rho[SW-1] || (in_rho == '0);
      side_ff[0]  <= in_side;
   end

   // one shift-and-subtract step per stage
   for (genvar k = 1; k < QW; k++) begin : g_step
      logic [SW:0]   rx2, ry2;
      logic          sbx, sby;
      logic [QW-1:0] qx, qy;

      always_comb begin
         rx2 = {remx_ff[k-1], 1'b0};
         ry2 = {remy_ff[k-1], 1'b0};
         sbx = rx2 >= {1'b0, rho_ff[k-1]};
         sby = ry2 >= {1'b0, rho_ff[k-1]};
         qx  = quox_ff[k-1];
         qy  = quoy_ff[k-1];
         qx[FRAC_BITS-k] = sbx;
         qy[FRAC_BITS-k] = sby;
      end

      always_ff @(posedge clock) begin
         rho_ff[k]   <= rho_ff[k-1];
         remx_ff[k]  <= sbx ? SW'(rx2 - {1'b0, rho_ff[k-1]}) : rx2[SW-1:0];
         remy_ff[k]  <= sby ? SW'(ry2 - {1'b0, rho_ff[k-1]}) : ry2[SW-1:0];
         quox_ff[k]  <= qx;
         quoy_ff[k]  <= qy;
         negx_ff[k]  <= negx_ff[k-1];
         negy_ff[k]  <= negy_ff[k-1];
         satx_ff[k]  <= satx_ff[k-1];
         saty_ff[k]  <= saty_ff[k-1];
         fault_ff[k] <= fault_ff[k-1];
         side_ff[k]  <= side_ff[k-1];
      end
   end

   // sign, clamp to |u| < 2, zero on bad density
   function automatic logic signed [UW-1:0] velo(input logic neg, input logic sat,
                                                 input logic flt, input logic [QW-1:0] q);
      logic signed [UW-1:0] v;
      if (flt) begin
         v = '0;
      end else if (sat) begin
         v = neg ? U_MIN : U_MAX;
      end else begin
         v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
      end
      return v;
   endfunction

   always_comb begin
      ux_in = velo(negx_ff[QW-1], satx_ff[QW-1], fault_ff[QW-1], quox_ff[QW-1]);
      uy_in = velo(negy_ff[QW-1], saty_ff[QW-1], fault_ff[QW-1], quoy_ff[QW-1]);
   end

   always_ff @(posedge clock) begin
      ux_ff     <= ux_in;
      uy_ff     <= uy_in;
      ofault_ff <= fault_ff[QW-1];
      oside_ff  <= side_ff[QW-1];
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QW; i++) begin
            valid_ff[i] <= 1'b0;
         end
         ovalid_ff <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < QW; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
         ovalid_ff <= valid_ff[QW-1];
      end
   end

   assign out_valid = ovalid_ff;
   assign out_ux    = ux_ff;
   assign out_uy    = uy_ff;
   assign out_fault = ofault_ff;
   assign out_side  = oside_ff;

endmodule

// ----- design/d2q9_relax.sv -----
// Equilibrium polynomial, equilibrium populations and BGK relaxation, seven stages.
module d2q9_relax #(
   parameter int FRAC_BITS = d2q9_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic signed [FRAC_BITS+1:0]        in_ux,
   input  logic signed [FRAC_BITS+1:0]        in_uy,
   input  logic                               in_fault,
   input  d2q9_pkg::side_type                 in_side,
   input  logic [d2q9_pkg::RATE_W-1:0]        omega,
   output logic                               out_strobe,
   output d2q9_pkg::rsp_type                  out_data
);

   localparam int UW = FRAC_BITS + 2;
   localparam int CW = FRAC_BITS + 3;
   localparam int RLW = d2q9_pkg::RATE_W + 34;
   localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

   // valid per stage (index 1..7); fault and side data up to stage 6
   logic               v_ff [1:7];
   logic               flt_ff [1:6];
   d2q9_pkg::side_type sd_ff [1:6];

   // R1
   logic signed [UW-1:0]   r1_ux_ff, r1_uy_ff;
   logic signed [CW-1:0]   r1_cp_ff, r1_cm_ff;
   // R2
   logic signed [UW-1:0]   r2_ux_ff, r2_uy_ff;
   logic signed [CW-1:0]   r2_cp_ff, r2_cm_ff;
   logic signed [2*UW-1:0] r2_pxx_ff, r2_pyy_ff;
   logic signed [2*CW-1:0] r2_ppp_ff, r2_pmm_ff;
   // R3..R7
   logic signed [31:0]     poly_ff [9];
   logic signed [31:0]     poly_in [9];
   logic signed [63:0]     fp_ff [9];
   logic signed [63:0]     fp_in [9];
   logic signed [32:0]     diff_ff [9];
   logic signed [32:0]     diff_in [9];
   logic signed [RLW-1:0]  rel_ff [9];
   logic signed [RLW-1:0]  rel_in [9];
   logic [8:0][31:0]       nv_in;
   d2q9_pkg::rsp_type      out_ff;

   // population of direction q from a side word
   function automatic logic signed [31:0] pop(input d2q9_pkg::side_type s, input int q);
      return $signed(s.pops[8-q]);
   endfunction

   // weighted density for direction q
   function automatic logic signed [31:0] tsel(input d2q9_pkg::side_type s, input int q);
      logic signed [31:0] t;
      if (q == 0) begin
         t = s.t_rest;
      end else if (q < 5) begin
         t = s.t_axis;
      end else begin
         t = s.t_diag;
      end
      return t;
   endfunction

   // R3: polynomial 1 + 3cu + (9 cu^2 - 3 u^2) / 2
   always_comb begin
      logic signed [63:0] cu [9];
      logic signed [63:0] sq [9];
      logic signed [63:0] usq, hv, h;
      usq   = (64'(r2_pxx_ff) + 64'(r2_pyy_ff)) >>> FRAC_BITS;
      cu[0] = '0;              sq[0] = '0;
      cu[1] = 64'(r2_ux_ff);   sq[1] = 64'(r2_pxx_ff) >>> FRAC_BITS;
      cu[2] = 64'(r2_uy_ff);   sq[2] = 64'(r2_pyy_ff) >>> FRAC_BITS;
      cu[3] = -64'(r2_ux_ff);  sq[3] = sq[1];
      cu[4] = -64'(r2_uy_ff);  sq[4] = sq[2];
      cu[5] = 64'(r2_cp_ff);   sq[5] = 64'(r2_ppp_ff) >>> FRAC_BITS;
      cu[6] = -64'(r2_cm_ff);  sq[6] = 64'(r2_pmm_ff) >>> FRAC_BITS;
      cu[7] = -64'(r2_cp_ff);  sq[7] = sq[5];
      cu[8] = 64'(r2_cm_ff);   sq[8] = sq[6];
      for (int q = 0; q < 9; q++) begin
         hv = 64'sd9 * sq[q] - 64'sd3 * usq;
         h  = hv[63] ? ((hv + 64'sd1) >>> 1) : (hv >>> 1);
         poly_in[q] = d2q9_pkg::sat32(ONE + 64'sd3 * cu[q] + h);
      end
   end

   // R4..R7 datapath per direction
   always_comb begin
      logic signed [31:0] feq;
      logic signed [63:0] nv;
      for (int q = 0; q < 9; q++) begin
         fp_in[q]   = 64'(tsel(sd_ff[3], q)) * 64'(poly_ff[q]);
         feq        = d2q9_pkg::sat32(fp_ff[q] >>> FRAC_BITS);
         diff_in[q] = 33'(feq) - 33'(pop(sd_ff[4], q));
         rel_in[q]  = RLW'($signed({1'b0, omega})) * RLW'(diff_ff[q]);
         nv         = 64'(pop(sd_ff[6], q)) + 64'(rel_ff[q] >>> d2q9_pkg::OMEGA_FRAC);
         nv_in[8-q] = d2q9_pkg::sat32(nv);
      end
   end

   // payload
   always_ff @(posedge clock) begin
      r1_ux_ff  <= in_ux;
      r1_uy_ff  <= in_uy;
      r1_cp_ff  <= CW'(in_ux) + CW'(in_uy);
      r1_cm_ff  <= CW'(in_ux) - CW'(in_uy);
      r2_ux_ff  <= r1_ux_ff;
      r2_uy_ff  <= r1_uy_ff;
      r2_cp_ff  <= r1_cp_ff;
      r2_cm_ff  <= r1_cm_ff;
      r2_pxx_ff <= (2*UW)'(r1_ux_ff) * (2*UW)'(r1_ux_ff);
      r2_pyy_ff <= (2*UW)'(r1_uy_ff) * (2*UW)'(r1_uy_ff);
      r2_ppp_ff <= (2*CW)'(r1_cp_ff) * (2*CW)'(r1_cp_ff);
      r2_pmm_ff <= (2*CW)'(r1_cm_ff) * (2*CW)'(r1_cm_ff);
      for (int q = 0; q < 9; q++) begin
         poly_ff[q] <= poly_in[q];
         fp_ff[q]   <= fp_in[q];
         diff_ff[q] <= diff_in[q];
         rel_ff[q]  <= rel_in[q];
      end
      out_ff <= {nv_in, flt_ff[6]};
      sd_ff[1]  <= in_side;
      flt_ff[1] <= in_fault;
      for (int i = 2; i < 7; i++) begin
         sd_ff[i]  <= sd_ff[i-1];
         flt_ff[i] <= flt_ff[i-1];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i < 8; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else begin
         v_ff[1] <= in_valid;
         for (int i = 2; i < 8; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   assign out_strobe = v_ff[7];
   assign out_data   = out_ff;

endmodule

// ----- design/d2q9_bgk_cell_collision.sv -----
// Throughput: one cell word per cycle; set by the velocity divider, one quotient bit
// per stage over FRAC_BITS+1 stages, with all other arithmetic pipelined alongside.
// busy is always low and the receiver cannot stall; results come out in order.
// Reset clears all pipeline valid bits and sets the relaxation rate to 1.0.
// Top level of the D2Q9 BGK cell collision pipeline.
module d2q9_bgk_cell_collision #(
   parameter int FRAC_BITS = d2q9_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  d2q9_pkg::req_type            req_data,
   output logic                         rsp_strobe,
   output d2q9_pkg::rsp_type            rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [d2q9_pkg::RATE_W-1:0]  csr_data
);

   localparam int LAT = FRAC_BITS + 13;
   localparam int SW  = d2q9_pkg::SUM_W;

   logic [d2q9_pkg::RATE_W-1:0] rate_ff;
   logic                        accept;

   logic                        m_valid;
   logic signed [SW-1:0]        m_rho, m_jx, m_jy;
   d2q9_pkg::side_type          m_side;

   logic                        d_valid, d_fault;
   logic signed [FRAC_BITS+1:0] d_ux, d_uy;
   d2q9_pkg::side_type          d_side;

   // the pipeline never blocks
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // relaxation rate register
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= d2q9_pkg::RATE_RESET;
      end else if (csr_valid && csr_ready) begin
         rate_ff <= csr_data;
      end
   end

   d2q9_moments #(.FRAC_BITS(FRAC_BITS)) u_moments (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (req_data),
      .out_valid (m_valid),
      .out_rho   (m_rho),
      .out_jx    (m_jx),
      .out_jy    (m_jy),
      .out_side  (m_side)
   );

   d2q9_divider #(.FRAC_BITS(FRAC_BITS)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m_valid),
      .in_rho    (m_rho),
      .in_jx     (m_jx),
      .in_jy     (m_jy),
      .in_side   (m_side),
      .out_valid (d_valid),
      .out_ux    (d_ux),
      .out_uy    (d_uy),
      .out_fault (d_fault),
      .out_side  (d_side)
   );

   d2q9_relax #(.FRAC_BITS(FRAC_BITS)) u_relax (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (d_valid),
      .in_ux      (d_ux),
      .in_uy      (d_uy),
      .in_fault   (d_fault),
      .in_side    (d_side),
      .omega      (rate_ff),
      .out_strobe (rsp_strobe),
      .out_data   (rsp_data)
   );

   // every result word traces back to an accepted cell word
   a_strobe_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LAT))
      else $error("result word without matching request");

   // a faulted cell leaves the divider with zero velocity
   a_fault_zero_vel: assert property (@(posedge clock) disable iff (reset)
      (d_valid && d_fault) |-> (d_ux == '0 && d_uy == '0))
      else $error("velocity not zero on density fault");

   // a rate write lands in the register on the next cycle
   a_rate_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> (rate_ff == $past(csr_data)))
      else $error("relaxation rate not updated");

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the D2Q9 BGK cell collision pipeline.
module tb;

   localparam int  FB       = d2q9_pkg::FRAC_BITS_DEF;
   localparam int  NDIR     = d2q9_pkg::NDIR;
   localparam int  RATE_W   = d2q9_pkg::RATE_W;
   localparam int  LATENCY  = FB + 12;
   localparam int  N_RANDOM = 1000;
   localparam int  MAX_CYC  = 400000;
   localparam logic [RATE_W-1:0] RATE_ZERO = '0;
   localparam logic [RATE_W-1:0] RATE_ONE  = 26'd16777216;
   localparam logic [RATE_W-1:0] RATE_TWO  = 26'd33554432;
   localparam logic [RATE_W-1:0] RATE_TOP  = '1;

   // velocity components per direction, rest first
   localparam int VX [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
   localparam int VY [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
   localparam int WN [NDIR] = '{4, 1, 1, 1, 1, 1, 1, 1, 1};
   localparam int WD [NDIR] = '{9, 9, 9, 9, 9, 36, 36, 36, 36};

   // collision scoreboard: predicts each relaxed cell and matches it in order
   class collision_board;
      logic [RATE_W-1:0]  omega;
      d2q9_pkg::rsp_type  due_q[$];
      int                 n_cells;
      int                 n_checked;
      int                 n_faults;
      int                 n_bad;

      function new();
         omega = d2q9_pkg::RATE_RESET;
      endfunction

      function longint clip32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // work out the relaxed populations of one accepted cell
      function void note_cell(d2q9_pkg::req_type c);
         longint f [NDIR];
         longint one, rho, jx, jy, ux, uy, usq, cu, sq, poly, w, t, feq, nv;
         d2q9_pkg::rsp_type r;
         longint res [NDIR];
         one = longint'(1) << FB;
         f = '{c.pop_rest, c.pop_east, c.pop_north, c.pop_west, c.pop_south,
               c.pop_northeast, c.pop_northwest, c.pop_southwest, c.pop_southeast};
         rho = 0; jx = 0; jy = 0; ux = 0; uy = 0;
         for (int q = 0; q < NDIR; q++) begin
            rho += f[q];
            jx  += VX[q] * f[q];
            jy  += VY[q] * f[q];
         end
         if (rho > 0) begin
            ux = (jx * one) / rho;
            uy = (jy * one) / rho;
            if (ux > 2 * one - 1) ux = 2 * one - 1;
            if (ux < -2 * one) ux = -2 * one;
            if (uy > 2 * one - 1) uy = 2 * one - 1;
            if (uy < -2 * one) uy = -2 * one;
         end
         usq = (ux * ux + uy * uy) >>> FB;
         for (int q = 0; q < NDIR; q++) begin
            cu   = VX[q] * ux + VY[q] * uy;
            sq   = (cu * cu) >>> FB;
            poly = clip32(one + 3 * cu + (9 * sq - 3 * usq) / 2);
            w    = (2 * WN[q] * one + WD[q]) / (2 * WD[q]);
            t    = clip32((rho * w) >>> FB);
            feq  = clip32((t * poly) >>> FB);
            nv   = clip32(f[q] + ((longint'({1'b0, omega}) * (feq - f[q])) >>> 24));
            res[q] = nv;
         end
         r.new_rest      = res[0][31:0];
         r.new_east      = res[1][31:0];
         r.new_north     = res[2][31:0];
         r.new_west      = res[3][31:0];
         r.new_south     = res[4][31:0];
         r.new_northeast = res[5][31:0];
         r.new_northwest = res[6][31:0];
         r.new_southwest = res[7][31:0];
         r.new_southeast = res[8][31:0];
         r.density_fault = (rho <= 0);
         if (rho <= 0) n_faults++;
         n_cells++;
         due_q.push_back(r);
      endfunction

      function void mismatch(string what, longint e, longint a);
         n_bad++;
         if (n_bad <= 10)
            $display("mismatch %s on cell %0d: expected %0d, got %0d",
                     what, n_checked, e, a);
      endfunction

      // match one result word against the oldest prediction
      function void check_cell(d2q9_pkg::rsp_type a);
         d2q9_pkg::rsp_type e;
         if (due_q.size() == 0) begin
            n_bad++;
            if (n_bad <= 10) $display("unexpected result word %h", a);
            return;
         end
         e = due_q.pop_front();
         if (a.new_rest != e.new_rest) mismatch("new_rest", e.new_rest, a.new_rest);
         if (a.new_east != e.new_east) mismatch("new_east", e.new_east, a.new_east);
         if (a.new_north != e.new_north) mismatch("new_north", e.new_north, a.new_north);
         if (a.new_west != e.new_west) mismatch("new_west", e.new_west, a.new_west);
         if (a.new_south != e.new_south) mismatch("new_south", e.new_south, a.new_south);
         if (a.new_northeast != e.new_northeast)
            mismatch("new_northeast", e.new_northeast, a.new_northeast);
         if (a.new_northwest != e.new_northwest)
            mismatch("new_northwest", e.new_northwest, a.new_northwest);
         if (a.new_southwest != e.new_southwest)
            mismatch("new_southwest", e.new_southwest, a.new_southwest);
         if (a.new_southeast != e.new_southeast)
            mismatch("new_southeast", e.new_southeast, a.new_southeast);
         if (a.density_fault !== e.density_fault)
            mismatch("density_fault", e.density_fault, a.density_fault);
         n_checked++;
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   d2q9_pkg::req_type req_data;
   logic              rsp_strobe;
   d2q9_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [RATE_W-1:0] csr_data;

   collision_board board = new();
   int             cycles;
   int             n_rates;

   d2q9_bgk_cell_collision uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // clock
   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   // monitor: note accepted cells, check result words, guard the run length
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note_cell(req_data);
         if (rsp_strobe) board.check_cell(rsp_data);
      end
      cycles++;
      if (cycles > MAX_CYC) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb: failure");
         $finish;
      end
   end

   function automatic d2q9_pkg::req_type make_cell(longint p [NDIR]);
      d2q9_pkg::req_type c;
      c.pop_rest      = p[0][31:0];
      c.pop_east      = p[1][31:0];
      c.pop_north     = p[2][31:0];
      c.pop_west      = p[3][31:0];
      c.pop_south     = p[4][31:0];
      c.pop_northeast = p[5][31:0];
      c.pop_northwest = p[6][31:0];
      c.pop_southwest = p[7][31:0];
      c.pop_southeast = p[8][31:0];
      return c;
   endfunction

   // near-equilibrium cell with a random drift: the usual working range
   function automatic d2q9_pkg::req_type flowing_cell();
      longint p [NDIR];
      longint rho, ux, uy;
      rho = $urandom_range(1 << 28, 1 << 20);
      ux  = longint'($urandom_range(200, 0)) - 100;
      uy  = longint'($urandom_range(200, 0)) - 100;
      for (int q = 0; q < NDIR; q++)
         p[q] = (rho * WN[q] / WD[q]) * (1000 + 3 * (VX[q] * ux + VY[q] * uy)) / 1000
                + longint'($urandom_range(4096, 0)) - 2048;
      return make_cell(p);
   endfunction

   function automatic d2q9_pkg::req_type noise_cell();
      longint p [NDIR];
      int sh;
      sh = $urandom_range(31, 0);
      for (int q = 0; q < NDIR; q++)
         p[q] = (sh == 31) ? longint'(int'($urandom()))
                           : longint'(int'($urandom())) >>> $urandom_range(31 - sh, 0);
      return make_cell(p);
   endfunction

   // hand one cell word over; start stays high until it is taken
   task automatic send_cell(d2q9_pkg::req_type c, bit may_idle);
      while (may_idle && $urandom_range(99, 0) < 20) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= c;
      do @(posedge clock); while (!(start && !busy));
   endtask

   // drain the pipe, then load a new relaxation rate
   task automatic set_rate(logic [RATE_W-1:0] v);
      start <= 1'b0;
      while (board.due_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      board.omega = v;
      n_rates++;
   endtask

   task automatic run_random(int n, logic [RATE_W-1:0] rate);
      int calm_from;
      set_rate(rate);
      calm_from = n / 3;
      for (int i = 0; i < n; i++)
         send_cell(($urandom_range(99, 0) < 75) ? flowing_cell() : noise_cell(),
                   !(i >= calm_from && i < calm_from + n / 4));
      start <= 1'b0;
   endtask

   // stimulus
   initial begin
      longint p [NDIR];
      longint one;
      one       = longint'(1) << FB;
      cycles    = 0;
      n_rates   = 0;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed cells at the reset rate of one
      p = '{default: 0};
      send_cell(make_cell(p), 1'b0);                      // zero density
      p = '{default: 2147483647};
      send_cell(make_cell(p), 1'b0);                      // all at the top
      p = '{default: -2147483648};
      send_cell(make_cell(p), 1'b0);                      // all at the bottom
      p = '{default: -one};
      send_cell(make_cell(p), 1'b0);                      // negative density
      p = '{-2147483648, 2147483647, -2147483648, 2147483647, -2147483648,
            2147483647, -2147483648, 2147483647, -2147483648};
      send_cell(make_cell(p), 1'b0);
      p = '{default: 0}; p[0] = one;
      send_cell(make_cell(p), 1'b0);                      // rest only
      for (int q = 0; q < NDIR; q++) p[q] = one * WN[q] / WD[q];
      send_cell(make_cell(p), 1'b0);                      // at equilibrium
      p = '{default: 0}; p[1] = one; p[3] = -(one * 6 / 10);
      send_cell(make_cell(p), 1'b0);                      // x velocity clamps
      p = '{default: 0}; p[4] = one; p[2] = -(one * 6 / 10);
      send_cell(make_cell(p), 1'b0);                      // y velocity clamps
      p = '{default: 0}; p[5] = 2147483647; p[7] = -2147483000;
      send_cell(make_cell(p), 1'b0);                      // tiny density, huge flow
      p = '{default: 0}; p[6] = one; p[8] = -one;
      send_cell(make_cell(p), 1'b0);                      // zero density with flow
      p = '{default: 0}; p[1] = 1;
      send_cell(make_cell(p), 1'b0);                      // smallest density
      start <= 1'b0;

      // directed extremes of the rate
      set_rate(RATE_ZERO);
      send_cell(flowing_cell(), 1'b0);
      send_cell(noise_cell(), 1'b0);
      set_rate(RATE_TOP);
      p = '{default: 2147483647}; p[0] = -2147483648;
      send_cell(make_cell(p), 1'b0);
      send_cell(flowing_cell(), 1'b0);
      send_cell(noise_cell(), 1'b0);
      start <= 1'b0;

      // random phases over several rates
      run_random(N_RANDOM * 3 / 10, RATE_TWO);
      run_random(N_RANDOM / 10, RATE_ZERO);
      run_random(N_RANDOM * 3 / 10, RATE_ONE);
      run_random(N_RANDOM / 10, RATE_TOP);
      run_random(N_RANDOM / 5, RATE_W'($urandom_range(33554432, 0)));

      while (board.due_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);

      $display("checked %0d cells (%0d with non-positive density) over %0d rate settings",
               board.n_checked, board.n_faults, n_rates + 1);
      $display("%0d mismatches", board.n_bad);
      if (board.n_bad == 0 && board.due_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
